### design/weightless_ram_classifier_assert.svh
// Assertion macros shared by the classifier checker.
`ifndef WEIGHTLESS_RAM_CLASSIFIER_ASSERT_SVH
`define WEIGHTLESS_RAM_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wrc assertion failed");

// next-cycle implication, disabled in reset
`define WRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wrc assertion failed");

`endif

### design/wrc_pkg.sv
// Types, constants and field layout for the weightless RAM classifier.
package wrc_pkg;

    localparam int NEURONS      = 8;
    localparam int CLASSES      = 4;
    localparam int NETWORKS     = 4;
    localparam int ADDR_ENTRIES = 8;

    localparam int SENSORS  = 3;
    localparam int THR_W    = 2;
    localparam int SENS_W   = 16;
    localparam int CFG_W    = 48;
    localparam int OP_W     = 2;
    localparam int NET_W    = 2;
    localparam int LBL_W    = 2;
    localparam int CHOSEN_W = 2;
    localparam int SCORE_W  = 4;

    localparam int ADDR_W    = $clog2(ADDR_ENTRIES);
    localparam int CLS_IDX_W = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int ROWS      = NETWORKS * CLASSES;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SUM_W     = $clog2(NEURONS + 1);

    // input tdata layout, lowest field first
    localparam int NET_LSB   = 0;
    localparam int S0_LSB    = NET_LSB + NET_W;
    localparam int S1_LSB    = S0_LSB + SENS_W;
    localparam int S2_LSB    = S1_LSB + SENS_W;
    localparam int LBL_LSB   = S2_LSB + SENS_W;
    localparam int S_FIELD_W = LBL_LSB + LBL_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;

    // output tdata layout
    localparam int CHOSEN_LSB = 0;
    localparam int SCORE_LSB  = CHOSEN_LSB + CHOSEN_W;
    localparam int M_FIELD_W  = SCORE_LSB + SCORE_W;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 2'd0,
        OP_TRAIN    = 2'd1,
        OP_CLASSIFY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_ACC,
        S_DONE
    } t_state;

    typedef logic [NEURONS-1:0][ADDR_W-1:0]       t_addr_vec;
    typedef logic [NEURONS-1:0][ADDR_ENTRIES-1:0] t_row;
    typedef logic [SENSORS-1:0][SENS_W-1:0]       t_sensors;

endpackage

### design/weightless_ram_classifier.sv
// Top level of the weightless RAM classifier: sequencer and row store.
// Clear goes S_RD, S_DONE; train S_RD, S_ACC (row write), S_DONE; classify repeats
// S_RD, S_ACC for each class, then S_DONE. One item is in work at a time: the next
// input is accepted only after the result is registered. The row store has one port,
// so each class row is read, then scored. Reset (synchronous, active low) clears the
// per-row valid bits, so the store reads as zero at once; no sweep.
module weightless_ram_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [wrc_pkg::CFG_W-1:0]       i_cfg_wr_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // network_select, sensor_0, sensor_1, sensor_2, class_label, zero pad
    input  logic [wrc_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // opcode
    input  logic [wrc_pkg::OP_W-1:0]        i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // chosen_class, best_score, zero pad
    output logic [wrc_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    wrc_pkg::t_state                  r_state, n_state;
    logic [wrc_pkg::CFG_W-1:0]        r_thr;
    wrc_pkg::t_op                     r_op;
    logic [wrc_pkg::NET_W-1:0]        r_net;
    logic [wrc_pkg::LBL_W-1:0]        r_label;
    wrc_pkg::t_addr_vec               r_addr;
    logic [wrc_pkg::CLS_IDX_W-1:0]    r_cnt;
    logic [wrc_pkg::SUM_W-1:0]        r_best;
    logic [wrc_pkg::CLS_IDX_W-1:0]    r_chosen;
    logic                             r_m_valid;
    logic [wrc_pkg::CHOSEN_W-1:0]     r_m_chosen;
    logic [wrc_pkg::SCORE_W-1:0]      r_m_score;

    wrc_pkg::t_row                    mem [wrc_pkg::ROWS];
    wrc_pkg::t_row                    r_rd_data;
    logic                             r_rd_vld;
    logic [wrc_pkg::ROWS-1:0]         r_row_vld;

    wrc_pkg::t_sensors                sensors;
    wrc_pkg::t_addr_vec               addr_vec;
    logic                             s_acc;
    logic                             net_ok, lbl_ok, last_cls;
    logic                             rd_en, wr_en, clr_en, acc_en, out_load;
    logic [wrc_pkg::CLS_IDX_W-1:0]    row_cls;
    logic [wrc_pkg::ROW_AW-1:0]       row_addr;
    wrc_pkg::t_row                    cur_row, new_row;
    logic [wrc_pkg::SUM_W-1:0]        sum;

    assign sensors[0] = i_s_axis_tdata[wrc_pkg::S0_LSB +: wrc_pkg::SENS_W];
    assign sensors[1] = i_s_axis_tdata[wrc_pkg::S1_LSB +: wrc_pkg::SENS_W];
    assign sensors[2] = i_s_axis_tdata[wrc_pkg::S2_LSB +: wrc_pkg::SENS_W];

    wrc_addr u_addr (
        .i_sensors    (sensors),
        .i_thresholds (r_thr),
        .o_addr       (addr_vec)
    );

    assign o_s_axis_tready = (r_state == wrc_pkg::S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign net_ok   = int'(r_net) < wrc_pkg::NETWORKS;
    assign lbl_ok   = int'(r_label) < wrc_pkg::CLASSES;
    assign last_cls = (r_cnt == wrc_pkg::CLS_IDX_W'(wrc_pkg::CLASSES - 1));
    assign row_cls  = (r_op == wrc_pkg::OP_TRAIN) ? wrc_pkg::CLS_IDX_W'(r_label) : r_cnt;
    assign row_addr = wrc_pkg::ROW_AW'(int'(r_net) * wrc_pkg::CLASSES + int'(row_cls));

    always_comb begin
        cur_row = r_rd_vld ? r_rd_data : '0;
        new_row = cur_row;
        sum     = '0;
        for (int n = 0; n < wrc_pkg::NEURONS; n++) begin
            new_row[n][r_addr[n]] = 1'b1;
            sum = sum + wrc_pkg::SUM_W'(cur_row[n][r_addr[n]]);
        end
    end

    always_comb begin
        n_state  = r_state;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        clr_en   = 1'b0;
        acc_en   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            wrc_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_state = wrc_pkg::S_RD;
                end
            end
            wrc_pkg::S_RD: begin
                unique case (r_op)
                    wrc_pkg::OP_CLEAR: begin
                        clr_en  = net_ok;
                        n_state = wrc_pkg::S_DONE;
                    end
                    wrc_pkg::OP_TRAIN: begin
                        rd_en   = net_ok && lbl_ok;
                        n_state = (net_ok && lbl_ok) ? wrc_pkg::S_ACC : wrc_pkg::S_DONE;
                    end
                    wrc_pkg::OP_CLASSIFY: begin
                        rd_en   = net_ok;
                        n_state = net_ok ? wrc_pkg::S_ACC : wrc_pkg::S_DONE;
                    end
                    default: begin
                        n_state = wrc_pkg::S_DONE;
                    end
                endcase
            end
            wrc_pkg::S_ACC: begin
                if (r_op == wrc_pkg::OP_TRAIN) begin
                    wr_en   = 1'b1;
                    n_state = wrc_pkg::S_DONE;
                end else begin
                    acc_en  = 1'b1;
                    n_state = last_cls ? wrc_pkg::S_DONE : wrc_pkg::S_RD;
                end
            end
            wrc_pkg::S_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = wrc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wrc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wrc_pkg::S_IDLE;
            r_thr     <= '0;
            r_m_valid <= 1'b0;
            r_row_vld <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (wr_en) begin
                r_row_vld[row_addr] <= 1'b1;
            end
            if (clr_en) begin
                for (int c = 0; c < wrc_pkg::CLASSES; c++) begin
                    r_row_vld[wrc_pkg::ROW_AW'(int'(r_net) * wrc_pkg::CLASSES + c)] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op     <= wrc_pkg::t_op'(i_s_axis_tuser);
            r_net    <= i_s_axis_tdata[wrc_pkg::NET_LSB +: wrc_pkg::NET_W];
            r_label  <= i_s_axis_tdata[wrc_pkg::LBL_LSB +: wrc_pkg::LBL_W];
            r_addr   <= addr_vec;
            r_cnt    <= '0;
            r_best   <= '0;
            r_chosen <= '0;
        end else if (acc_en) begin
            r_cnt <= r_cnt + 1'b1;
            if (sum > r_best) begin
                r_best   <= sum;
                r_chosen <= r_cnt;
            end
        end
        if (out_load) begin
            r_m_chosen <= wrc_pkg::CHOSEN_W'(r_chosen);
            r_m_score  <= wrc_pkg::SCORE_W'(r_best);
        end
    end

    // row store: one port, read data registered
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[row_addr] <= new_row;
        end
        if (rd_en) begin
            r_rd_data <= mem[row_addr];
            r_rd_vld  <= r_row_vld[row_addr];
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(wrc_pkg::M_TDATA_W - wrc_pkg::M_FIELD_W){1'b0}},
                              r_m_score, r_m_chosen};

endmodule

### design/wrc_addr.sv
// Per-neuron RAM address generation from sensor readings and thresholds.
module wrc_addr (
    input  wrc_pkg::t_sensors             i_sensors,
    input  logic [wrc_pkg::CFG_W-1:0]     i_thresholds,
    output wrc_pkg::t_addr_vec            o_addr
);

    for (genvar n = 0; n < wrc_pkg::NEURONS; n++) begin : g_neuron
        for (genvar s = 0; s < wrc_pkg::ADDR_W; s++) begin : g_bit
            localparam int POS = (n * wrc_pkg::SENSORS + s) * wrc_pkg::THR_W;
            logic [wrc_pkg::THR_W-1:0] thr;

            if (s < wrc_pkg::SENSORS && POS + wrc_pkg::THR_W <= wrc_pkg::CFG_W) begin : g_thr
                assign thr = i_thresholds[POS +: wrc_pkg::THR_W];
            end else begin : g_zero
                assign thr = '0;
            end

            if (s < wrc_pkg::SENSORS) begin : g_cmp
                assign o_addr[n][s] = $signed(i_sensors[s]) <=
                    $signed({{(wrc_pkg::SENS_W - wrc_pkg::THR_W){1'b0}}, thr});
            end else begin : g_pad
                assign o_addr[n][s] = 1'b0 & thr[0];
            end
        end
    end

endmodule

### design/wrc_checker.sv
// Port-level assertion checker for the classifier, with its bind.
`include "weightless_ram_classifier_assert.svh"

module wrc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [wrc_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    logic [wrc_pkg::CHOSEN_W-1:0] chosen;
    logic [wrc_pkg::SCORE_W-1:0]  score;
    logic                         stall;
    logic                         s_acc;

    assign chosen = o_m_axis_tdata[wrc_pkg::CHOSEN_LSB +: wrc_pkg::CHOSEN_W];
    assign score  = o_m_axis_tdata[wrc_pkg::SCORE_LSB +: wrc_pkg::SCORE_W];
    assign stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;

    `WRC_ASSERT_NXT(a_out_valid_hold, i_clk, i_rst_n, stall, o_m_axis_tvalid)
    `WRC_ASSERT_NXT(a_out_data_hold, i_clk, i_rst_n, stall, $stable(o_m_axis_tdata))
    `WRC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_acc, !o_s_axis_tready)
    `WRC_ASSERT_IMP(a_score_bound, i_clk, i_rst_n, o_m_axis_tvalid, int'(score) <= wrc_pkg::NEURONS)
    `WRC_ASSERT_IMP(a_class_needs_score, i_clk, i_rst_n, o_m_axis_tvalid && (chosen != '0), score != '0)

endmodule

bind weightless_ram_classifier wrc_checker u_wrc_checker (.*);
